>>> rtl/gfs_pkg.sv
// gaussian forward splat package: command type between front and back,
// and the per-axis gaussian weight table built at elaboration; no dependencies
`timescale 1ns / 1ps
package gfs_pkg;

    // largest axis distance (Q8.8) held in the weight table; larger distances weigh zero
    localparam int WTAB_LAST = 1254;
    localparam int WTAB_W    = 17;
    localparam longint unsigned E_INV_Q32 = 64'd1580030169;
    localparam int SERIES_TERMS = 10;

    typedef logic [WTAB_W-1:0] wtab_t [0:WTAB_LAST];

    // one queued request, already classified and clipped
    typedef struct packed {
        logic        is_read;
        logic        hit;
        logic [8:0]  lox;
        logic [8:0]  hix;
        logic [8:0]  loy;
        logic [8:0]  hiy;
        logic [10:0] flx;
        logic [10:0] fly;
        logic [7:0]  fracx;
        logic [7:0]  fracy;
        logic [19:0] area;
    } cmd_t;

    // restoring shift-subtract quotient, only used while building the table
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-d^2/2) in Q1.16, series for the fraction, e^-1 steps for the integer part
    function automatic wtab_t build_wtab();
        wtab_t            t;
        longint unsigned  v;
        longint unsigned  f;
        longint unsigned  term;
        longint unsigned  r;
        longint           sum;
        longint unsigned  ip;
        for (int d = 0; d <= WTAB_LAST; d++)
        begin
            v = (longint'(d) * longint'(d)) >> 1;
            if (v >= (64'd12 << 16))
            begin
                t[d] = '0;
            end
            else
            begin
                ip   = v >> 16;
                f    = v & 64'hFFFF;
                term = 64'd1 << 32;
                sum  = longint'(term);
                for (int n = 1; n <= SERIES_TERMS; n++)
                begin
                    term = udiv64(term * f, longint'(n) << 16);
                    if ((n & 1) == 1)
                        sum = sum - longint'(term);
                    else
                        sum = sum + longint'(term);
                end
                r = (sum < 0) ? 64'd0 : longint'(sum);
                for (int m = 0; m < 12; m++)
                begin
                    if (longint'(m) < longint'(ip))
                        r = (r * E_INV_Q32 + (64'd1 << 31)) >> 32;
                end
                t[d] = WTAB_W'((r + 64'd32768) >> 16);
            end
        end
        return t;
    endfunction

    localparam wtab_t WTAB = build_wtab();

endpackage

>>> rtl/gfs_ram.sv
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies
`timescale 1ns / 1ps
module gfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gfs_front.sv
// front end: config registers, request classification and window clipping,
// two-entry command queue toward the back end; uses gfs_pkg
`timescale 1ns / 1ps
module gfs_front #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int WINDOW_RADIUS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               hold,
    input  logic               req_type,
    input  logic [7:0]         pos_x,
    input  logic [7:0]         pos_y,
    input  logic signed [16:0] flow_dx,
    input  logic signed [16:0] flow_dy,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output logic               cmd_valid,
    input  logic               cmd_take,
    output gfs_pkg::cmd_t      cmd
);
    import gfs_pkg::*;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic signed [11:0] RS = 12'(WINDOW_RADIUS);

    typedef struct packed {
        logic        hit;
        logic [8:0]  lo;
        logic [8:0]  hi;
        logic [10:0] fl;
        logic [7:0]  frac;
    } axis_t;

    function automatic logic [8:0] eff_size(logic [8:0] v, logic [12:0] mx);
        logic [8:0] e;
        if (v == 9'd0)
            e = 9'd1;
        else if ({4'b0, v} > mx)
            e = mx[8:0];
        else
            e = v;
        return e;
    endfunction

    function automatic axis_t clip_axis(logic [7:0] pos, logic signed [16:0] flow,
                                        logic [8:0] eff);
        logic signed [18:0] t;
        logic signed [11:0] fl;
        logic signed [11:0] lo;
        logic signed [11:0] hi;
        logic signed [11:0] top;
        axis_t a;
        t   = $signed({3'b000, pos, 8'h00}) + $signed({{2{flow[16]}}, flow});
        fl  = $signed({t[18], t[18:8]});
        lo  = fl - RS;
        hi  = fl + RS;
        top = $signed({3'b000, eff}) - 12'sd1;
        if (lo < 12'sd0)
            lo = 12'sd0;
        if (hi > top)
            hi = top;
        a.hit  = !(lo > hi);
        a.lo   = lo[8:0];
        a.hi   = hi[8:0];
        a.fl   = fl[10:0];
        a.frac = t[7:0];
        return a;
    endfunction

    logic [8:0] width_reg, width_next;
    logic [8:0] height_reg, height_next;
    cmd_t       q_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic [8:0] eff_w;
    logic [8:0] eff_h;
    axis_t      ax;
    axis_t      ay;
    cmd_t       new_cmd;
    logic       push_ok;

    assign cfg_ready = 1'b1;
    assign eff_w = eff_size(width_reg, 13'(MAX_WIDTH));
    assign eff_h = eff_size(height_reg, 13'(MAX_HEIGHT));
    assign ax = clip_axis(pos_x, flow_dx, eff_w);
    assign ay = clip_axis(pos_y, flow_dy, eff_h);

    always_comb
    begin
        new_cmd = '0;
        new_cmd.is_read = req_type;
        if (req_type)
        begin
            new_cmd.hit = ({1'b0, pos_x} < eff_w) && ({1'b0, pos_y} < eff_h);
            new_cmd.lox = {1'b0, pos_x};
            new_cmd.loy = {1'b0, pos_y};
        end
        else
        begin
            new_cmd.hit   = ax.hit && ay.hit;
            new_cmd.lox   = ax.lo;
            new_cmd.hix   = ax.hi;
            new_cmd.loy   = ay.lo;
            new_cmd.hiy   = ay.hi;
            new_cmd.flx   = ax.fl;
            new_cmd.fly   = ay.fl;
            new_cmd.fracx = ax.frac;
            new_cmd.fracy = ay.frac;
            new_cmd.area  = 20'(({1'b0, ax.hi} - {1'b0, ax.lo} + 10'd1)
                               * ({1'b0, ay.hi} - {1'b0, ay.lo} + 10'd1));
        end
    end

    assign full      = (cnt_reg == 2'd2) || hold;
    assign push_ok   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_next  = cfg_data;
                REG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
        end
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_take ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_ok} - {1'b0, cmd_take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/gfs_back.sv
// back end: store clearing pass, tap walker with pipelined read-modify-write,
// read-and-clear, result register; uses gfs_pkg and gfs_ram
`timescale 1ns / 1ps
module gfs_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_take,
    input  gfs_pkg::cmd_t cmd,
    output logic          clearing,
    output logic          empty,
    input  logic          pop,
    output logic [31:0]   value,
    output logic          landed
);
    import gfs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_READ  = 5'b10000
    } bstate_t;

    function automatic logic [AW-1:0] addr_of(logic [8:0] x, logic [8:0] y);
        return AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    function automatic logic [16:0] weight(logic [8:0] n, logic [10:0] fl,
                                           logic [7:0] frac);
        logic signed [11:0] k;
        logic signed [20:0] d;
        logic [16:0]        g;
        k = $signed({3'b000, n}) - $signed({fl[10], fl});
        if (k > 12'sd0)
            d = $signed({k[11], k, 8'h00}) - $signed({13'b0, frac});
        else
            d = $signed({13'b0, frac}) - $signed({k[11], k, 8'h00});
        if (d > $signed(21'(WTAB_LAST)))
            g = '0;
        else
            g = WTAB[d[10:0]];
        return g;
    endfunction

    bstate_t        state_reg, state_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    logic [8:0]     nx_reg, nx_next;
    logic [8:0]     ny_reg, ny_next;
    cmd_t           cur_reg;
    logic           v1_reg, v1_next;
    logic           v2_reg, v2_next;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    value_reg;
    logic           landed_reg;
    logic [16:0]    gx_reg;
    logic [16:0]    gy_reg;
    logic [AW-1:0]  addr1_reg;
    logic [AW-1:0]  addr2_reg;
    logic [16:0]    wt_reg;
    logic [31:0]    rdata_reg;

    logic           re;
    logic [AW-1:0]  raddr;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;
    logic [31:0]    rdata;
    logic           take;
    logic           issue;
    logic           fill;
    logic [31:0]    fill_value;
    logic           fill_landed;
    logic [33:0]    prod;
    logic [32:0]    sum;

    gfs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign clearing = (state_reg == ST_CLEAR);
    assign take     = (state_reg == ST_IDLE) && cmd_valid && !out_valid_reg;
    assign cmd_take = take;
    assign issue    = (state_reg == ST_RUN);
    assign prod     = gx_reg * gy_reg;
    assign sum      = {1'b0, rdata_reg} + {16'b0, wt_reg};

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        nx_next       = nx_reg;
        ny_next       = ny_reg;
        v1_next       = issue;
        v2_next       = v1_reg;
        fill          = 1'b0;
        fill_value    = 32'd0;
        fill_landed   = 1'b1;
        re            = 1'b0;
        raddr         = addr_of(nx_reg, ny_reg);
        we            = 1'b0;
        waddr         = addr2_reg;
        wdata         = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_addr_reg;
                wdata = 32'd0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    if (cmd.is_read && cmd.hit)
                    begin
                        re         = 1'b1;
                        raddr      = addr_of(cmd.lox, cmd.loy);
                        state_next = ST_READ;
                    end
                    else if (!cmd.is_read && cmd.hit)
                    begin
                        nx_next    = cmd.lox;
                        ny_next    = cmd.loy;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // read outside image or splat that misses the image
                        fill        = 1'b1;
                        fill_landed = cmd.is_read;
                    end
                end
            end
            ST_RUN:
            begin
                re = 1'b1;
                if (nx_reg == cur_reg.hix)
                begin
                    nx_next = cur_reg.lox;
                    ny_next = ny_reg + 1'b1;
                    if (ny_reg == cur_reg.hiy)
                        state_next = ST_DRAIN;
                end
                else
                begin
                    nx_next = nx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    fill       = 1'b1;
                    fill_value = {12'b0, cur_reg.area};
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                we         = 1'b1;
                waddr      = addr_of(cur_reg.lox, cur_reg.loy);
                wdata      = 32'd0;
                fill       = 1'b1;
                fill_value = rdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (v2_reg)
            we = 1'b1;

        out_valid_next = fill ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        if (take)
            cur_reg <= cmd;
        if (issue)
        begin
            gx_reg    <= weight(nx_reg, cur_reg.flx, cur_reg.fracx);
            gy_reg    <= weight(ny_reg, cur_reg.fly, cur_reg.fracy);
            addr1_reg <= raddr;
        end
        wt_reg    <= 17'((35'(prod) + 35'd32768) >> 16);
        rdata_reg <= rdata;
        addr2_reg <= addr1_reg;
        if (fill)
        begin
            value_reg  <= fill_value;
            landed_reg <= fill_landed;
        end
    end

    assign empty  = !out_valid_reg;
    assign value  = value_reg;
    assign landed = landed_reg;

endmodule

>>> rtl/gaussian_forward_splat_core.sv
// gaussian forward splat core: an accepted command waits in the front queue for the back end,
// then a splat goes through take, one store read-modify-write issued per cycle over the clipped
// window, then a pipe drain; a read returns and clears its word, a miss only sets the result;
// one request in the back end at a time, the next is taken once the result is popped,
// up to two more queue in the front; reset: asynchronous active low, config to 256 x 256,
// then a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT store words while full stays high
`timescale 1ns / 1ps
module gaussian_forward_splat_core #(
    parameter int MAX_WIDTH     = 256,
    parameter int MAX_HEIGHT    = 256,
    parameter int WINDOW_RADIUS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side, a transaction is push while not full
    input  logic               push,
    output logic               full,
    input  logic               req_type,
    input  logic [7:0]         pos_x,
    input  logic [7:0]         pos_y,
    input  logic signed [16:0] flow_dx,
    input  logic signed [16:0] flow_dy,
    // result side, a transaction is pop while not empty
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        value,
    output logic               landed,
    // register writes: index 0 image width, index 1 image height
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    import gfs_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    logic clearing;

    // front: classifies reads vs splats, clips the window, queues the command
    gfs_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .WINDOW_RADIUS (WINDOW_RADIUS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .hold      (clearing),
        .req_type  (req_type),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .flow_dx   (flow_dx),
        .flow_dy   (flow_dy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    // back: clears the store, walks the window taps against the accumulator store, serves reads
    gfs_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .value     (value),
        .landed    (landed)
    );

endmodule
